// ===== sv/scrattr_pkg.sv =====
// Shared types, constants and the color function of the screen attribute renderer.
`default_nettype none
package scrattr_pkg;

  localparam int OFF_W   = 13;
  localparam int BYTE_W  = 8;
  localparam int LEVEL_W = 8;
  localparam int COLOR_W = 24;
  localparam int LINE_W  = 3;
  localparam int CROW_W  = 5;
  localparam int COL_W   = 5;
  localparam int ATTR_W  = 10;
  localparam int LINEY_W = 8;
  localparam int PIX_N   = 8;

  localparam logic [LEVEL_W-1:0] NORMAL_RESET = 8'd215;
  localparam logic [LEVEL_W-1:0] BRIGHT_RESET = 8'd255;
  localparam logic [LINE_W-1:0]  LAST_LINE    = 3'd7;

  typedef enum logic {
    REG_NORMAL = 1'b0,
    REG_BRIGHT = 1'b1
  } reg_idx_t;

  typedef enum logic {
    ST_IDLE   = 1'b0,
    ST_RENDER = 1'b1
  } state_t;

  typedef struct packed {
    logic              wr_en;
    logic              cap_attr;
    logic              rd_en;
    logic [LINE_W-1:0] rd_line;
    logic              load_out;
  } cmd_t;

  typedef struct packed {
    logic is_bitmap;
    logic is_attr;
  } sts_t;

  // Color index is {bright, green, red, blue}; result is 0xRRGGBB.
  function automatic logic [COLOR_W-1:0] color_of(input logic [3:0] idx,
                                                  input logic [LEVEL_W-1:0] normal_lvl,
                                                  input logic [LEVEL_W-1:0] bright_lvl);
    logic [LEVEL_W-1:0] lvl;
    logic [LEVEL_W-1:0] r;
    logic [LEVEL_W-1:0] g;
    logic [LEVEL_W-1:0] b;
    lvl = idx[3] ? bright_lvl : normal_lvl;
    r = idx[1] ? lvl : '0;
    g = idx[2] ? lvl : '0;
    b = idx[0] ? lvl : '0;
    return {r, g, b};
  endfunction

endpackage
`default_nettype wire

// ===== sv/zx_screen_attribute_render_top.sv =====
// Top level of the screen attribute renderer: controller, datapath and checks.
//
// Channel | Direction | Handshake             | Payload
// in_     | input     | in_valid / in_ready   | byte_offset, byte_value
// out_    | output    | out_valid / out_ready | line_y, column_byte, colour_0..7, cell_done
// cfg_    | input     | cfg_we                | cfg_index, cfg_data
//
// A bitmap byte or an ignored offset is accepted without leaving the idle state.
// An attribute byte issues one bitmap store read per cycle, eight in all, while the output
// side does not stall; new input is taken once the read stage is empty.
// Output stalls hold the read stage and then the line sequencer.
// Reset is synchronous; the bitmap store is not cleared and needs no clearing pass.
`default_nettype none
module zx_screen_attribute_render_top
  import scrattr_pkg::*;
#(
  parameter int BITMAP_BYTES = 6144
) (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 cfg_we,
  input  wire                 cfg_index,
  input  wire  [LEVEL_W-1:0]  cfg_data,
  input  wire                 in_valid,
  output logic                in_ready,
  input  wire  [OFF_W-1:0]    in_byte_offset,
  input  wire  [BYTE_W-1:0]   in_byte_value,
  output logic                out_valid,
  input  wire                 out_ready,
  output logic [LINEY_W-1:0]  out_line_y,
  output logic [COL_W-1:0]    out_column_byte,
  output logic [COLOR_W-1:0]  out_colour_0,
  output logic [COLOR_W-1:0]  out_colour_1,
  output logic [COLOR_W-1:0]  out_colour_2,
  output logic [COLOR_W-1:0]  out_colour_3,
  output logic [COLOR_W-1:0]  out_colour_4,
  output logic [COLOR_W-1:0]  out_colour_5,
  output logic [COLOR_W-1:0]  out_colour_6,
  output logic [COLOR_W-1:0]  out_colour_7,
  output logic                out_cell_done
);

  cmd_t                          cmd;
  sts_t                          sts;
  logic [PIX_N-1:0][COLOR_W-1:0] colors;

  scrattr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  scrattr_dp #(
    .BITMAP_BYTES (BITMAP_BYTES)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_byte_offset  (in_byte_offset),
    .in_byte_value   (in_byte_value),
    .cmd             (cmd),
    .sts             (sts),
    .out_line_y      (out_line_y),
    .out_column_byte (out_column_byte),
    .out_colors      (colors),
    .out_cell_done   (out_cell_done)
  );

  assign out_colour_0 = colors[0];
  assign out_colour_1 = colors[1];
  assign out_colour_2 = colors[2];
  assign out_colour_3 = colors[3];
  assign out_colour_4 = colors[4];
  assign out_colour_5 = colors[5];
  assign out_colour_6 = colors[6];
  assign out_colour_7 = colors[7];

  a_wr_rd_excl: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.wr_en |-> !cmd.rd_en)
    else $error("bitmap write and read issued together");

  a_attr_starts_read: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && sts.is_attr) |=> cmd.rd_en)
    else $error("attribute transaction did not start a bitmap read");

  a_load_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> !in_ready)
    else $error("input accepted while read stage still holds a line");

endmodule
`default_nettype wire

// ===== sv/scrattr_ctrl.sv =====
// Controller state machine: input acceptance, line sequencing and output stage flags.
`default_nettype none
module scrattr_ctrl
  import scrattr_pkg::*;
(
  input  wire  clk,
  input  wire  rst_n,
  input  wire  in_valid,
  output logic in_ready,
  output logic out_valid,
  input  wire  out_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t            state_r, state_nxt;
  logic [LINE_W-1:0] line_r, line_nxt;
  logic              rd_vld_r, rd_vld_nxt;
  logic              out_vld_r, out_vld_nxt;
  logic              accept;
  logic              load;
  logic              issue;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      line_r    <= '0;
      rd_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      line_r    <= line_nxt;
      rd_vld_r  <= rd_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    line_nxt     = line_r;
    in_ready     = 1'b0;
    accept       = 1'b0;
    issue        = 1'b0;
    load         = rd_vld_r && (!out_vld_r || out_ready);
    cmd          = '0;
    cmd.load_out = load;
    cmd.rd_line  = line_r;
    case (state_r)
      ST_IDLE: begin
        in_ready     = !rd_vld_r;
        accept       = in_valid && !rd_vld_r;
        cmd.wr_en    = accept && sts.is_bitmap;
        cmd.cap_attr = accept && sts.is_attr;
        if (accept && sts.is_attr) begin
          line_nxt  = '0;
          state_nxt = ST_RENDER;
        end
      end
      ST_RENDER: begin
        issue      = !rd_vld_r || load;
        cmd.rd_en  = issue;
        if (issue) begin
          line_nxt = line_r + 1'b1;
          if (line_r == LAST_LINE) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
    rd_vld_nxt  = issue ? 1'b1 : (load ? 1'b0 : rd_vld_r);
    out_vld_nxt = load ? 1'b1 : (out_ready ? 1'b0 : out_vld_r);
    out_valid   = out_vld_r;
  end

endmodule
`default_nettype wire

// ===== sv/scrattr_dp.sv =====
// Datapath: level registers, bitmap store, address generation and pixel color stage.
`default_nettype none
module scrattr_dp
  import scrattr_pkg::*;
#(
  parameter int BITMAP_BYTES = 6144
) (
  input  wire                      clk,
  input  wire                      rst_n,
  input  wire                      cfg_we,
  input  wire                      cfg_index,
  input  wire  [LEVEL_W-1:0]       cfg_data,
  input  wire  [OFF_W-1:0]         in_byte_offset,
  input  wire  [BYTE_W-1:0]        in_byte_value,
  input  cmd_t                     cmd,
  output sts_t                     sts,
  output logic [LINEY_W-1:0]       out_line_y,
  output logic [COL_W-1:0]         out_column_byte,
  output logic [PIX_N-1:0][COLOR_W-1:0] out_colors,
  output logic                     out_cell_done
);

  localparam int AW = $clog2(BITMAP_BYTES);
  localparam logic [OFF_W:0] BMP_END  = (OFF_W + 1)'(BITMAP_BYTES);
  localparam logic [OFF_W:0] ATTR_END = (OFF_W + 1)'(BITMAP_BYTES + BITMAP_BYTES / 8);

  logic [LEVEL_W-1:0] normal_r;
  logic [LEVEL_W-1:0] bright_r;
  logic [BYTE_W-1:0]  bitmap_mem_r [BITMAP_BYTES];

  logic [CROW_W-1:0]  crow_r;
  logic [COL_W-1:0]   col_r;
  logic [COLOR_W-1:0] ink_r;
  logic [COLOR_W-1:0] paper_r;

  logic [BYTE_W-1:0]  rd_data_r;
  logic               rd_zero_r;
  logic [LINE_W-1:0]  rd_line_r;

  logic [LINEY_W-1:0]            line_y_r;
  logic [COL_W-1:0]              col_out_r;
  logic [PIX_N-1:0][COLOR_W-1:0] colors_r;
  logic                          done_r;

  logic [OFF_W:0]     off_ext;
  logic [OFF_W-1:0]   attr_off;
  logic [OFF_W-1:0]   rd_addr;
  logic               rd_in_range;
  logic [BYTE_W-1:0]  pix_bits;

  assign off_ext       = {1'b0, in_byte_offset};
  assign sts.is_bitmap = off_ext < BMP_END;
  assign sts.is_attr   = (off_ext >= BMP_END) && (off_ext < ATTR_END);
  assign attr_off      = in_byte_offset - OFF_W'(BITMAP_BYTES);

  // Interleaved screen address: third, pixel line, character row within third, column.
  assign rd_addr     = {crow_r[4:3], cmd.rd_line, crow_r[2:0], col_r};
  assign rd_in_range = {1'b0, rd_addr} < BMP_END;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      normal_r <= NORMAL_RESET;
      bright_r <= BRIGHT_RESET;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_NORMAL: normal_r <= cfg_data;
        REG_BRIGHT: bright_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      bitmap_mem_r[in_byte_offset[AW-1:0]] <= in_byte_value;
    end
    if (cmd.rd_en && rd_in_range) begin
      rd_data_r <= bitmap_mem_r[rd_addr[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cap_attr) begin
      crow_r  <= attr_off[ATTR_W-1:COL_W];
      col_r   <= attr_off[COL_W-1:0];
      ink_r   <= color_of({in_byte_value[6], in_byte_value[2:0]}, normal_r, bright_r);
      paper_r <= color_of({in_byte_value[6], in_byte_value[5:3]}, normal_r, bright_r);
    end
    if (cmd.rd_en) begin
      rd_zero_r <= !rd_in_range;
      rd_line_r <= cmd.rd_line;
    end
  end

  assign pix_bits = rd_zero_r ? '0 : rd_data_r;

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      line_y_r  <= {crow_r, rd_line_r};
      col_out_r <= col_r;
      done_r    <= (rd_line_r == LAST_LINE);
      for (int p = 0; p < PIX_N; p++) begin
        colors_r[p] <= pix_bits[PIX_N-1-p] ? ink_r : paper_r;
      end
    end
  end

  assign out_line_y      = line_y_r;
  assign out_column_byte = col_out_r;
  assign out_colors      = colors_r;
  assign out_cell_done   = done_r;

endmodule
`default_nettype wire
